// ===== rtl/signature_region_carver_defines.svh =====
// Assertion macros shared by the signature region carver RTL.
`ifndef SIGNATURE_REGION_CARVER_DEFINES_SVH
`define SIGNATURE_REGION_CARVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/src_pkg.sv =====
// Types and constants of the signature region carver.
package src_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 5;
    localparam int DIST_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_HEAD_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_PAT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_LEN  = 3'd4;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_HEAD_MISS = 2'd1;
    localparam logic [1:0] ST_TAIL_MISS = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] region_start;
        logic [31:0] region_length;
        logic        stream_end;
    } out_beat_t;

    typedef struct packed {
        logic              head_hit;
        logic              tail_hit;
        logic              early_hit;
        logic [DIST_W-1:0] early_dd;
    } match_t;

endpackage

// ===== rtl/src_cell.sv =====
// One window cell: holds a stream byte, passes it on, compares it to every signature byte.
module src_cell
    import src_pkg::*;
#(
    parameter int HEAD_N = 10,
    parameter int TAIL_N = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    shift,
    input  logic [7:0]              byte_in,
    output logic [7:0]              byte_out,
    input  logic [HEAD_N-1:0][7:0]  head_bytes,
    input  logic [TAIL_N-1:0][7:0]  tail_bytes,
    output logic [HEAD_N-1:0]       head_eq,
    output logic [TAIL_N-1:0]       tail_eq
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    always_comb
    begin
        for (int i = 0; i < HEAD_N; i++)
        begin
            head_eq[i] = (byte_reg == head_bytes[i]);
        end
        for (int j = 0; j < TAIL_N; j++)
        begin
            tail_eq[j] = (byte_reg == tail_bytes[j]);
        end
    end

endmodule

// ===== rtl/src_match.sv =====
// Combines the cells' byte compares into head and tail hits for the current lengths.
module src_match
    import src_pkg::*;
#(
    parameter int HEAD_N = 10,
    parameter int TAIL_N = 8
)
(
    input  logic [HEAD_N-1:0][HEAD_N-1:0] head_eq,
    input  logic [HEAD_N-1:0][TAIL_N-1:0] tail_eq,
    input  logic [LEN_W-1:0]              head_span,
    input  logic [LEN_W-1:0]              tail_span,
    output match_t                        hits
);

    localparam int IDX_W = (HEAD_N > 1) ? $clog2(HEAD_N) : 1;

    logic [HEAD_N-1:0] head_at;
    logic [HEAD_N-1:0] tail_at;
    logic [LEN_W-1:0]  head_last;
    logic [LEN_W-1:0]  tail_last;

    assign head_last = head_span - LEN_W'(1);
    assign tail_last = tail_span - LEN_W'(1);

    // head_at[h]: a head of h+1 bytes ends at the newest cell
    // tail_at[dd]: a tail of tail_span bytes starts dd cells back
    always_comb
    begin
        for (int h = 0; h < HEAD_N; h++)
        begin
            head_at[h] = 1'b1;
            for (int i = 0; i < HEAD_N; i++)
            begin
                if (i <= h)
                begin
                    head_at[h] = head_at[h] & head_eq[h - i][i];
                end
            end
        end
        for (int dd = 0; dd < HEAD_N; dd++)
        begin
            tail_at[dd] = 1'b1;
            for (int i = 0; i < TAIL_N; i++)
            begin
                if (LEN_W'(i) < tail_span)
                begin
                    if (i <= dd)
                    begin
                        tail_at[dd] = tail_at[dd] & tail_eq[dd - i][i];
                    end
                    else
                    begin
                        tail_at[dd] = 1'b0;
                    end
                end
            end
        end
    end

    // earliest tail at or after the head start: largest distance wins
    always_comb
    begin
        hits.head_hit  = head_at[head_last[IDX_W-1:0]];
        hits.tail_hit  = tail_at[tail_last[IDX_W-1:0]];
        hits.early_hit = 1'b0;
        hits.early_dd  = '0;
        for (int dd = 0; dd < HEAD_N; dd++)
        begin
            if ((LEN_W'(dd) >= tail_last) && (LEN_W'(dd) < head_span) && tail_at[dd])
            begin
                hits.early_hit = 1'b1;
                hits.early_dd  = DIST_W'(dd);
            end
        end
    end

endmodule

// ===== rtl/signature_region_carver.sv =====
// Top level of the signature region carver: cell chain, offset tracking, result register.
//
//   beat      | dir | handshake              | payload
//   in_data   | in  | in_valid / in_stall    | data_byte, last_byte
//   out_data  | out | out_valid / out_stall  | status, region_start, region_length, stream_end
//   cfg       | in  | cfg_we                 | cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; a byte passes the cell chain, then the result register.
// The cell chain shifts on each accepted beat; the match stage reads it, held while out_stall blocks.
// Reset clears the window, offset, search state and patterns, lengths to 1; no clearing pass.
// An output stall holds a valid result; a beat is still taken while the match stage is empty.
`include "signature_region_carver_defines.svh"

module signature_region_carver
    import src_pkg::*;
#(
    parameter int MAX_HEAD_LEN = 10,
    parameter int MAX_TAIL_LEN = 8,
    parameter int OFFSET_BITS  = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_beat_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int OB       = OFFSET_BITS;
    localparam int TAIL_CAP = (MAX_TAIL_LEN < MAX_HEAD_LEN) ? MAX_TAIL_LEN : MAX_HEAD_LEN;

    logic [63:0] head_pattern_low_reg;
    logic [15:0] head_pattern_high_reg;
    logic [3:0]  head_length_reg;
    logic [63:0] tail_pattern_reg;
    logic [3:0]  tail_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_pattern_low_reg  <= '0;
            head_pattern_high_reg <= '0;
            head_length_reg       <= 4'd1;
            tail_pattern_reg      <= '0;
            tail_length_reg       <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HEAD_LOW:  head_pattern_low_reg  <= cfg_data;
                REG_HEAD_HIGH: head_pattern_high_reg <= cfg_data[15:0];
                REG_HEAD_LEN:  head_length_reg       <= cfg_data[3:0];
                REG_TAIL_PAT:  tail_pattern_reg      <= cfg_data;
                REG_TAIL_LEN:  tail_length_reg       <= cfg_data[3:0];
                default:       ;
            endcase
        end
    end

    logic [LEN_W-1:0] head_span;
    logic [LEN_W-1:0] tail_span;

    always_comb
    begin
        head_span = {1'b0, head_length_reg};
        if (head_span == '0)
        begin
            head_span = LEN_W'(1);
        end
        if (head_span > LEN_W'(MAX_HEAD_LEN))
        begin
            head_span = LEN_W'(MAX_HEAD_LEN);
        end
        tail_span = {1'b0, tail_length_reg};
        if (tail_span == '0)
        begin
            tail_span = LEN_W'(1);
        end
        if (tail_span > LEN_W'(TAIL_CAP))
        begin
            tail_span = LEN_W'(TAIL_CAP);
        end
    end

    logic [MAX_HEAD_LEN-1:0][7:0] head_bytes;
    logic [MAX_TAIL_LEN-1:0][7:0] tail_bytes;

    for (genvar i = 0; i < MAX_HEAD_LEN; i++)
    begin : g_head_byte
        if (i < 8)
        begin : g_low
            assign head_bytes[i] = head_pattern_low_reg[8*i +: 8];
        end
        else if (i < 10)
        begin : g_high
            assign head_bytes[i] = head_pattern_high_reg[8*(i-8) +: 8];
        end
        else
        begin : g_zero
            assign head_bytes[i] = 8'd0;
        end
    end

    for (genvar j = 0; j < MAX_TAIL_LEN; j++)
    begin : g_tail_byte
        assign tail_bytes[j] = tail_pattern_reg[8*j +: 8];
    end

    // handshake and stage control
    logic a_valid_reg;
    logic a_last_reg;
    logic r_valid_reg;
    logic b_go;
    logic in_take;

    assign b_go     = a_valid_reg && (!r_valid_reg || !out_stall);
    assign in_stall = a_valid_reg && !b_go;
    assign in_take  = in_valid && !in_stall;

    // cell chain, newest byte in cell 0
    logic [MAX_HEAD_LEN-1:0][7:0]              chain_bytes;
    logic [MAX_HEAD_LEN-1:0][MAX_HEAD_LEN-1:0] head_eq;
    logic [MAX_HEAD_LEN-1:0][MAX_TAIL_LEN-1:0] tail_eq;

    for (genvar k = 0; k < MAX_HEAD_LEN; k++)
    begin : g_cell
        logic [7:0] feed;
        if (k == 0)
        begin : g_first
            assign feed = in_data.data_byte;
        end
        else
        begin : g_next
            assign feed = chain_bytes[k-1];
        end
        src_cell #(
            .HEAD_N (MAX_HEAD_LEN),
            .TAIL_N (MAX_TAIL_LEN)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (in_take),
            .byte_in    (feed),
            .byte_out   (chain_bytes[k]),
            .head_bytes (head_bytes),
            .tail_bytes (tail_bytes),
            .head_eq    (head_eq[k]),
            .tail_eq    (tail_eq[k])
        );
    end

    match_t hits;

    src_match #(
        .HEAD_N (MAX_HEAD_LEN),
        .TAIL_N (MAX_TAIL_LEN)
    ) u_match (
        .head_eq   (head_eq),
        .tail_eq   (tail_eq),
        .head_span (head_span),
        .tail_span (tail_span),
        .hits      (hits)
    );

    // byte offset, saturating
    logic [OB-1:0] byte_offset_reg;
    logic [OB-1:0] p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg <= '0;
            a_valid_reg     <= 1'b0;
            a_last_reg      <= 1'b0;
            p_reg           <= '0;
        end
        else
        begin
            if (in_take)
            begin
                p_reg      <= byte_offset_reg;
                a_last_reg <= in_data.last_byte;
                if (in_data.last_byte)
                begin
                    byte_offset_reg <= '0;
                end
                else if (byte_offset_reg != {OB{1'b1}})
                begin
                    byte_offset_reg <= byte_offset_reg + OB'(1);
                end
            end
            if (in_take)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (b_go)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    // match stage
    logic          seeking_reg;
    logic [OB-1:0] head_offset_reg;
    logic [OB-1:0] search_from_reg;

    logic [OB-1:0] head_back;
    logic [OB-1:0] tail_back;
    logic [OB-1:0] head_start;
    logic [OB-1:0] tail_start;
    logic [OB-1:0] early_start;
    logic          head_ok;
    logic          tail_ok;
    logic          found;
    logic [OB-1:0] ts;
    logic [OB-1:0] head_sel;
    logic          seek_now;
    logic [OB:0]   region_len;

    assign head_back   = OB'(head_span - LEN_W'(1));
    assign tail_back   = OB'(tail_span - LEN_W'(1));
    assign head_start  = p_reg - head_back;
    assign tail_start  = p_reg - tail_back;
    assign early_start = p_reg - OB'(hits.early_dd);

    assign head_ok = !seeking_reg && hits.head_hit && (p_reg >= head_back)
                     && (head_start >= search_from_reg);
    assign tail_ok = seeking_reg && hits.tail_hit && (p_reg >= tail_back)
                     && (tail_start >= search_from_reg);

    assign found      = tail_ok || (head_ok && hits.early_hit);
    assign ts         = tail_ok ? tail_start : early_start;
    assign head_sel   = head_ok ? head_start : head_offset_reg;
    assign seek_now   = seeking_reg || head_ok;
    assign region_len = (OB+1)'(ts) + (OB+1)'(tail_span) - (OB+1)'(head_sel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeking_reg     <= 1'b0;
            head_offset_reg <= '0;
            search_from_reg <= '0;
            r_valid_reg     <= 1'b0;
        end
        else
        begin
            if (b_go)
            begin
                if (a_last_reg)
                begin
                    seeking_reg     <= 1'b0;
                    head_offset_reg <= '0;
                    search_from_reg <= '0;
                end
                else if (found)
                begin
                    seeking_reg     <= 1'b0;
                    head_offset_reg <= head_sel;
                    search_from_reg <= ts;
                end
                else if (head_ok)
                begin
                    seeking_reg     <= 1'b1;
                    head_offset_reg <= head_start;
                    search_from_reg <= head_start;
                end
                r_valid_reg <= found || a_last_reg;
            end
            else if (!out_stall)
            begin
                r_valid_reg <= 1'b0;
            end
        end
    end

    out_beat_t r_data_reg;
    out_beat_t r_data_next;

    always_comb
    begin
        r_data_next.status        = ST_FOUND;
        r_data_next.region_start  = 32'(head_sel);
        r_data_next.region_length = 32'(region_len);
        r_data_next.stream_end    = a_last_reg;
        if (!found)
        begin
            r_data_next.status        = seek_now ? ST_TAIL_MISS : ST_HEAD_MISS;
            r_data_next.region_start  = seek_now ? 32'(head_sel) : 32'd0;
            r_data_next.region_length = 32'd0;
            r_data_next.stream_end    = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_go)
        begin
            r_data_reg <= r_data_next;
        end
    end

    assign out_valid = r_valid_reg;
    assign out_data  = r_data_reg;

    `SRC_ASSERT_IMP(a_stall_needs_item, !a_valid_reg, !in_stall,
        "input stalled with the match stage empty")
    `SRC_ASSERT_NXT(a_last_gives_result, b_go && a_last_reg,
        r_valid_reg && r_data_reg.stream_end, "stream end produced no closing result")
    `SRC_ASSERT_NXT(a_last_clears_search, b_go && a_last_reg,
        !seeking_reg && (search_from_reg == '0) && (head_offset_reg == '0),
        "search state not cleared at stream end")
    `SRC_ASSERT_IMP(a_seek_from_head, seeking_reg, search_from_reg == head_offset_reg,
        "tail search does not start at the pending head")

endmodule

// ===== test/signature_region_carver_tb.sv =====
// Self-checking testbench for the signature region carver with a built-in carving predictor.
module signature_region_carver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import src_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_beat_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_beat_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    signature_region_carver i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the registers and the scan state.
    logic [63:0] head_lo;
    logic [15:0] head_hi;
    logic [3:0]  head_span;
    logic [63:0] tail_pat;
    logic [3:0]  tail_span;
    logic [7:0]  recent [10];
    longint      scan_pos;
    bit          hunting_tail;
    longint      head_at;
    longint      resume_at;

    in_beat_t  byte_feed [$];
    out_beat_t region_q [$];
    int        fed_count;
    int        took_count;
    bit        in_took;
    int        errors;
    int        send_idle;
    int        recv_idle;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int eff_head();
        int n;
        n = int'(head_span);
        if (n == 0) n = 1;
        if (n > 10) n = 10;
        return n;
    endfunction

    function automatic int eff_tail();
        int n;
        n = int'(tail_span);
        if (n == 0) n = 1;
        if (n > 8) n = 8;
        return n;
    endfunction

    function automatic logic [7:0] head_sig(input int i);
        if (i < 8) return head_lo[8*i +: 8];
        if (i < 10) return head_hi[8*(i-8) +: 8];
        return 8'h00;
    endfunction

    function automatic logic [7:0] tail_sig(input int i);
        if (i < 8) return tail_pat[8*i +: 8];
        return 8'h00;
    endfunction

    // Signature starting d bytes back from the newest byte.
    function automatic bit sig_match(input bit is_head, input int d, input int len);
        for (int i = 0; i < len; i++)
        begin
            if (i > d) return 1'b0;
            if (recent[d-i] != (is_head ? head_sig(i) : tail_sig(i))) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_scan();
        foreach (recent[i]) recent[i] = 8'h00;
        scan_pos     = 0;
        hunting_tail = 1'b0;
        head_at      = 0;
        resume_at    = 0;
    endfunction

    function automatic bit carve_step(input in_beat_t beat, output out_beat_t res);
        int     hl;
        int     tl;
        int     d;
        longint p;
        longint ts;
        bit     hit;
        hl  = eff_head();
        tl  = eff_tail();
        p   = scan_pos;
        hit = 1'b0;
        ts  = 0;
        res = '0;
        for (int i = 9; i > 0; i--) recent[i] = recent[i-1];
        recent[0] = beat.data_byte;
        if (scan_pos < 64'hFFFF_FFFF) scan_pos++;
        if (!hunting_tail)
        begin
            d = hl - 1;
            if (p >= d && p - d >= resume_at && sig_match(1'b1, d, hl))
            begin
                head_at      = p - d;
                resume_at    = head_at;
                hunting_tail = 1'b1;
                for (int k = hl; k >= tl && k > 0; k--)
                begin
                    if (sig_match(1'b0, k - 1, tl))
                    begin
                        hit = 1'b1;
                        ts  = p - (k - 1);
                        break;
                    end
                end
            end
        end
        else
        begin
            d = tl - 1;
            if (p >= d && p - d >= resume_at && sig_match(1'b0, d, tl))
            begin
                hit = 1'b1;
                ts  = p - d;
            end
        end
        if (hit)
        begin
            res.status        = ST_FOUND;
            res.region_start  = head_at[31:0];
            res.region_length = 32'(ts + tl - head_at);
            res.stream_end    = beat.last_byte;
            hunting_tail      = 1'b0;
            resume_at         = ts;
        end
        else if (beat.last_byte)
        begin
            res.status        = hunting_tail ? ST_TAIL_MISS : ST_HEAD_MISS;
            res.region_start  = hunting_tail ? head_at[31:0] : 32'd0;
            res.region_length = 32'd0;
            res.stream_end    = 1'b1;
        end
        if (beat.last_byte) clear_scan();
        return hit || beat.last_byte;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= 30)
                $display("%0t %s mismatch: expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // Driver: next beat at the falling edge once the current one is taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_took)
            begin
                if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    in_data  <= byte_feed.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // Monitor: predict on every accepted input beat, check every accepted result.
    always @(posedge clk)
    begin : monitor
        out_beat_t pred;
        out_beat_t want;
        if (!rst_n)
        begin
            in_took <= 1'b0;
        end
        else
        begin
            in_took <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                took_count++;
                if (carve_step(in_data, pred)) region_q.push_back(pred);
            end
            if (out_valid && !out_stall)
            begin
                if (region_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 30)
                        $display("%0t unexpected result: expected none, got %h", $time,
                                 out_data);
                end
                else
                begin
                    want = region_q.pop_front();
                    check_field("status", 32'(want.status), 32'(out_data.status));
                    check_field("region_start", want.region_start, out_data.region_start);
                    check_field("region_length", want.region_length,
                                out_data.region_length);
                    check_field("stream_end", 32'(want.stream_end),
                                32'(out_data.stream_end));
                end
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_HEAD_LOW:  head_lo   = value;
            REG_HEAD_HIGH: head_hi   = value[15:0];
            REG_HEAD_LEN:  head_span = value[3:0];
            REG_TAIL_PAT:  tail_pat  = value;
            REG_TAIL_LEN:  tail_span = value[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b, input bit last);
        in_beat_t beat;
        beat.data_byte = b;
        beat.last_byte = last;
        byte_feed.push_back(beat);
        fed_count++;
    endtask

    // Stream written left to right in one literal, last flag on its final byte.
    task automatic push_literal(input logic [79:0] seq, input int n);
        for (int i = 0; i < n; i++) push_byte(seq[8*(n-1-i) +: 8], i == n - 1);
    endtask

    // Wait until every beat is taken and every region has come out.
    task automatic settle();
        do @(negedge clk);
        while (took_count != fed_count || region_q.size() != 0);
        repeat (6) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(3))
            0: return head_sig($urandom_range(eff_head() - 1));
            1: return tail_sig($urandom_range(eff_tail() - 1));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic make_stream(output int n);
        logic [7:0] s [$];
        int         hl;
        int         tl;
        int         kind;
        hl   = eff_head();
        tl   = eff_tail();
        kind = $urandom_range(9);
        repeat ($urandom_range(3)) s.push_back(pick_byte());
        if (kind <= 6)
        begin
            repeat ($urandom_range(1, 3))
            begin
                for (int i = 0; i < hl; i++) s.push_back(head_sig(i));
                repeat ($urandom_range(5)) s.push_back(pick_byte());
                for (int i = 0; i < tl; i++) s.push_back(tail_sig(i));
                repeat ($urandom_range(2)) s.push_back(pick_byte());
            end
        end
        else if (kind == 7)
        begin
            for (int i = 0; i < hl; i++) s.push_back(head_sig(i));
            repeat ($urandom_range(4)) s.push_back(pick_byte());
        end
        else if (kind == 8)
        begin
            repeat ($urandom_range(1, 12)) s.push_back(8'($urandom_range(255)));
        end
        else
        begin
            for (int i = 0; i < $urandom_range(hl - 1); i++) s.push_back(head_sig(i));
            repeat ($urandom_range(3)) s.push_back(pick_byte());
        end
        if (s.size() == 0) s.push_back(pick_byte());
        foreach (s[i]) push_byte(s[i], i == s.size() - 1);
        n = s.size();
    endtask

    task automatic pick_config(input int ph);
        logic [63:0] hlo;
        logic [63:0] hhi;
        logic [63:0] tp;
        int          hlen;
        int          tlen;
        hlo  = {$urandom, $urandom};
        hhi  = {$urandom, $urandom};
        tp   = {$urandom, $urandom};
        hlen = $urandom_range(1, 10);
        tlen = $urandom_range(1, 8);
        case (ph % 6)
            0:
            begin
                hlen = 10;
                tlen = 8;
            end
            1:
            begin
                hlen = 0;
                tlen = 15;
            end
            2:
            begin
                hlen = 15;
                tlen = 0;
            end
            3:
            begin
                hlen = $urandom_range(1, 8);
                tlen = hlen;
                tp   = hlo;
            end
            4:
            begin
                hlo = '1;
                hhi = '1;
                tp  = '1;
            end
            default: ;
        endcase
        cfg_write(REG_HEAD_LOW, hlo);
        cfg_write(REG_HEAD_HIGH, hhi);
        cfg_write(REG_HEAD_LEN, 64'(hlen));
        cfg_write(REG_TAIL_PAT, tp);
        cfg_write(REG_TAIL_LEN, 64'(tlen));
    endtask

    initial
    begin
        int n;
        int phase_bytes;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_stall  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        errors     = 0;
        fed_count  = 0;
        took_count = 0;
        send_idle  = 13;
        recv_idle  = 80;
        head_lo    = '0;
        head_hi    = '0;
        head_span  = 4'd1;
        tail_pat   = '0;
        tail_span  = 4'd1;
        clear_scan();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset patterns: single zero byte for head and tail.
        push_literal(80'h00_55_00, 3);
        settle();
        cfg_write(REG_HEAD_LOW, 64'hE1FF_D8FF);
        cfg_write(REG_HEAD_HIGH, '1);
        cfg_write(REG_HEAD_LEN, 64'd4);
        cfg_write(REG_TAIL_PAT, 64'hD9FF);
        cfg_write(REG_TAIL_LEN, 64'd2);
        push_literal(80'hFF_D8_FF_E1_45_FF_D9_00, 8);
        push_literal(80'h00, 1);
        push_literal(80'hFF_D8_FF_E1_AA, 5);
        settle();
        // Tail lying inside the head, found when the head completes on the final byte.
        cfg_write(REG_TAIL_PAT, 64'hFFD8);
        push_literal(80'hFF_D8_FF_E1, 4);
        settle();
        // Zero head must not match the cleared window before offset 0.
        cfg_write(REG_HEAD_LOW, 64'h0);
        cfg_write(REG_HEAD_LEN, 64'd3);
        cfg_write(REG_TAIL_PAT, 64'h45);
        cfg_write(REG_TAIL_LEN, 64'd1);
        push_literal(80'h00_00_00_45, 4);

        for (int ph = 0; ph < 12; ph++)
        begin
            settle();
            send_idle = (ph < 4) ? 13 : (ph < 8) ? 80 : 0;
            recv_idle = (ph < 4) ? 80 : (ph < 8) ? 13 : 0;
            pick_config(ph);
            phase_bytes = 0;
            while (phase_bytes < 40)
            begin
                make_stream(n);
                phase_bytes += n;
            end
        end
        settle();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
